@@ design/vat_pkg.sv @@
// shared types, constants and tables for the vertex affine transform
`timescale 1ns / 1ps
`default_nettype none

package vat_pkg;

  // default parameter values
  localparam int COORD_WIDTH  = 16;
  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 16;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ANGLE_W    = 14;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ANGLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_X        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_Y        = 3'd7;

  // transform modes, codes six and seven pass the vertex through
  localparam logic [2:0] MODE_TRANSLATE = 3'd0;
  localparam logic [2:0] MODE_ROTATE    = 3'd1;
  localparam logic [2:0] MODE_SCALE     = 3'd2;
  localparam logic [2:0] MODE_NEG_Y     = 3'd3;
  localparam logic [2:0] MODE_NEG_X     = 3'd4;
  localparam logic [2:0] MODE_SHEAR     = 3'd5;

  // scale factor of one in q8.8
  localparam logic signed [CFG_DATA_W-1:0] SCALE_ONE = 16'sd256;

  // trig unit
  localparam int TRIG_W      = 18;      // q1.14 cos/sin plus headroom
  localparam int TRIG_FRAC   = 14;
  localparam int Z_W         = 26;      // angle residual, degrees * 65536
  localparam int Z_SHIFT     = 12;      // sixteenths of a degree to degrees * 65536
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W  = 5;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 18'sd9949;
  localparam int TURN_SIXTEENTHS = 5760;
  localparam int HALF_TURN       = 2880;
  localparam int QUARTER_TURN    = 1440;

  typedef struct packed {
    logic        [2:0]            mode;
    logic signed [CFG_DATA_W-1:0] offset_x;
    logic signed [CFG_DATA_W-1:0] offset_y;
    logic signed [CFG_DATA_W-1:0] scale_x;
    logic signed [CFG_DATA_W-1:0] scale_y;
    logic signed [ANGLE_W-1:0]    rotation_angle;
    logic signed [CFG_DATA_W-1:0] shear_x;
    logic signed [CFG_DATA_W-1:0] shear_y;
  } cfg_t;

  typedef struct packed {
    logic                     busy;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;
  } trig_t;

  // arctangent of 2^-i in degrees * 65536
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:    r = 26'sd2949120;
      5'd1:    r = 26'sd1740967;
      5'd2:    r = 26'sd919879;
      5'd3:    r = 26'sd466945;
      5'd4:    r = 26'sd234379;
      5'd5:    r = 26'sd117304;
      5'd6:    r = 26'sd58666;
      5'd7:    r = 26'sd29335;
      5'd8:    r = 26'sd14668;
      5'd9:    r = 26'sd7334;
      5'd10:   r = 26'sd3667;
      5'd11:   r = 26'sd1833;
      5'd12:   r = 26'sd917;
      5'd13:   r = 26'sd458;
      5'd14:   r = 26'sd229;
      5'd15:   r = 26'sd115;
      5'd16:   r = 26'sd57;
      5'd17:   r = 26'sd29;
      5'd18:   r = 26'sd14;
      5'd19:   r = 26'sd7;
      5'd20:   r = 26'sd4;
      5'd21:   r = 26'sd2;
      5'd22:   r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/vat_regs.sv @@
// configuration register file
`timescale 1ns / 1ps
`default_nettype none

module vat_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [vat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [vat_pkg::CFG_DATA_W-1:0]      cfg_data,
  output vat_pkg::cfg_t                            cfg,
  output logic                                     angle_wr
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= vat_pkg::MODE_TRANSLATE;
      cfg.offset_x       <= '0;
      cfg.offset_y       <= '0;
      cfg.scale_x        <= vat_pkg::SCALE_ONE;
      cfg.scale_y        <= vat_pkg::SCALE_ONE;
      cfg.rotation_angle <= '0;
      cfg.shear_x        <= '0;
      cfg.shear_y        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vat_pkg::REG_MODE:           cfg.mode <= cfg_data[2:0];
        vat_pkg::REG_OFFSET_X:       cfg.offset_x <= cfg_data;
        vat_pkg::REG_OFFSET_Y:       cfg.offset_y <= cfg_data;
        vat_pkg::REG_SCALE_X:        cfg.scale_x <= cfg_data;
        vat_pkg::REG_SCALE_Y:        cfg.scale_y <= cfg_data;
        vat_pkg::REG_ROTATION_ANGLE: cfg.rotation_angle <= cfg_data[vat_pkg::ANGLE_W-1:0];
        vat_pkg::REG_SHEAR_X:        cfg.shear_x <= cfg_data;
        vat_pkg::REG_SHEAR_Y:        cfg.shear_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // restarts the trig unit
  assign angle_wr = cfg_we && (cfg_index == vat_pkg::REG_ROTATION_ANGLE);

endmodule

`default_nettype wire

@@ design/vat_cordic.sv @@
// iterative rotation-mode cordic producing cos and sin of the configured angle
`timescale 1ns / 1ps
`default_nettype none

module vat_cordic #(
  parameter int CORDIC_STEPS = vat_pkg::CORDIC_STEPS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [vat_pkg::ANGLE_W-1:0] angle,
  output vat_pkg::trig_t                          trig
);

  localparam int TW     = vat_pkg::TRIG_W;
  localparam int ZW     = vat_pkg::Z_W;
  localparam int AW     = vat_pkg::ANGLE_W + 1;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
  localparam logic signed [AW-1:0] HALF    = AW'(vat_pkg::HALF_TURN);
  localparam logic signed [AW-1:0] QUARTER = AW'(vat_pkg::QUARTER_TURN);
  localparam logic signed [AW-1:0] TURN    = AW'(vat_pkg::TURN_SIXTEENTHS);

  logic                  loading;
  logic [STEP_W-1:0]     step;
  logic                  flip;
  logic signed [TW-1:0]  cx;
  logic signed [TW-1:0]  cy;
  logic signed [ZW-1:0]  z;

  logic signed [AW-1:0]  ang_wrap;
  logic signed [AW-1:0]  ang_fold;
  logic                  flip_next;
  logic signed [TW-1:0]  cx_next;
  logic signed [TW-1:0]  cy_next;
  logic signed [ZW-1:0]  z_next;
  logic signed [ZW-1:0]  atan_k;

  // angle into (-180, 180], then fold into +-90 with a sign flip
  always_comb begin
    ang_wrap = AW'(angle);
    if (ang_wrap > HALF) begin
      ang_wrap = ang_wrap - TURN;
    end else if (ang_wrap <= -HALF) begin
      ang_wrap = ang_wrap + TURN;
    end
    ang_fold  = ang_wrap;
    flip_next = 1'b0;
    if (ang_wrap > QUARTER) begin
      ang_fold  = ang_wrap - HALF;
      flip_next = 1'b1;
    end else if (ang_wrap < -QUARTER) begin
      ang_fold  = ang_wrap + HALF;
      flip_next = 1'b1;
    end
  end

  // one micro-rotation
  always_comb begin
    atan_k = vat_pkg::atan_entry(vat_pkg::ATAN_IDX_W'(step));
    if (!z[ZW-1]) begin
      cx_next = cx - (cy >>> step);
      cy_next = cy + (cx >>> step);
      z_next  = z - atan_k;
    end else begin
      cx_next = cx + (cy >>> step);
      cy_next = cy - (cx >>> step);
      z_next  = z + atan_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig.busy <= 1'b1;
      loading   <= 1'b1;
      step      <= '0;
    end else if (start) begin
      trig.busy <= 1'b1;
      loading   <= 1'b1;
      step      <= '0;
    end else if (loading) begin
      loading <= 1'b0;
      flip    <= flip_next;
      cx      <= vat_pkg::CORDIC_GAIN_INV;
      cy      <= '0;
      z       <= ZW'(ang_fold) <<< vat_pkg::Z_SHIFT;
    end else if (trig.busy) begin
      cx <= cx_next;
      cy <= cy_next;
      z  <= z_next;
      if (step == LAST_STEP) begin
        trig.busy    <= 1'b0;
        trig.cos_val <= flip ? -cx_next : cx_next;
        trig.sin_val <= flip ? -cy_next : cy_next;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  a_done_after_last_step : assert property (@(posedge clk) disable iff (rst)
    $fell(trig.busy) |-> ($past(step) == LAST_STEP) && !$past(loading))
    else $error("trig unit finished early");

  a_load_before_steps : assert property (@(posedge clk) disable iff (rst)
    loading |-> trig.busy && (step == '0))
    else $error("trig unit loading while idle");

endmodule

`default_nettype wire

@@ design/vat_pipe.sv @@
// four-stage vertex datapath: multiply, combine, shear multiply, finish and saturate
`timescale 1ns / 1ps
`default_nettype none

module vat_pipe #(
  parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = vat_pkg::FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire vat_pkg::cfg_t                 cfg,
  input  wire vat_pkg::trig_t                trig,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] x_in,
  input  wire logic signed [COORD_WIDTH-1:0] y_in,
  input  wire logic                          last_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      x_out,
  output logic signed [COORD_WIDTH-1:0]      y_out,
  output logic                               last_out,
  output logic                               clipped
);

  localparam int CW = COORD_WIDTH;
  localparam int TW = vat_pkg::TRIG_W;
  localparam int PW = CW + TW;
  localparam int W2 = CW + 20;
  localparam int W3 = W2 + vat_pkg::CFG_DATA_W;
  localparam int W4 = W3 + 1;
  localparam logic signed [W4-1:0] COORD_MAX = W4'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [W4-1:0] COORD_MIN = -COORD_MAX - W4'(1);

  // truncating division by 2^s, rounds toward zero
  function automatic logic signed [W4-1:0] trunc_div(input logic signed [W4-1:0] v,
                                                     input int s);
    logic signed [W4-1:0] bias;
    bias = v[W4-1] ? ((W4'(1) <<< s) - W4'(1)) : '0;
    return (v + bias) >>> s;
  endfunction

  logic en1, en2, en3, en4;

  // stage 1 registers
  logic                  v1;
  logic signed [CW-1:0]  px1, py1;
  logic                  last1;
  logic signed [PW-1:0]  pa, pb, pc, pd;

  // stage 2 registers
  logic                  v2;
  logic signed [W2-1:0]  rx2, ry2;
  logic                  last2;

  // stage 3 registers
  logic                  v3;
  logic signed [W2-1:0]  rx3, ry3;
  logic signed [W3-1:0]  pe3;
  logic                  last3;

  logic signed [TW-1:0]  ma, mb, mc, md;
  logic signed [W4-1:0]  sum_a, sum_c;
  logic signed [W2-1:0]  rx2_next, ry2_next;
  logic signed [W4-1:0]  rx_full, ry_full;
  logic                  x_hi, x_lo, y_hi, y_lo;

  // each stage moves when its slot is free or drains
  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1 && !trig.busy;

  // multiplier operands per mode
  always_comb begin
    ma = '0;
    mb = '0;
    mc = '0;
    md = '0;
    case (cfg.mode)
      vat_pkg::MODE_ROTATE: begin
        ma = trig.cos_val;
        mb = trig.sin_val;
        mc = trig.sin_val;
        md = trig.cos_val;
      end
      vat_pkg::MODE_SCALE: begin
        ma = TW'(cfg.scale_x);
        md = TW'(cfg.scale_y);
      end
      vat_pkg::MODE_SHEAR: begin
        mb = TW'(cfg.shear_x);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      px1   <= x_in;
      py1   <= y_in;
      last1 <= last_in;
      pa    <= PW'(x_in) * PW'(ma);
      pb    <= PW'(y_in) * PW'(mb);
      pc    <= PW'(x_in) * PW'(mc);
      pd    <= PW'(y_in) * PW'(md);
    end
  end

  // combine products, offsets and negations
  always_comb begin
    sum_a    = W4'(pa) - W4'(pb);
    sum_c    = W4'(pc) + W4'(pd);
    rx2_next = W2'(px1);
    ry2_next = W2'(py1);
    case (cfg.mode)
      vat_pkg::MODE_TRANSLATE: begin
        rx2_next = W2'(px1) + W2'(cfg.offset_x);
        ry2_next = W2'(py1) + W2'(cfg.offset_y);
      end
      vat_pkg::MODE_ROTATE: begin
        rx2_next = W2'(trunc_div(sum_a, vat_pkg::TRIG_FRAC));
        ry2_next = W2'(trunc_div(sum_c, vat_pkg::TRIG_FRAC));
      end
      vat_pkg::MODE_SCALE: begin
        rx2_next = W2'(trunc_div(W4'(pa), FRAC_BITS));
        ry2_next = W2'(trunc_div(W4'(pd), FRAC_BITS));
      end
      vat_pkg::MODE_NEG_Y: ry2_next = -W2'(py1);
      vat_pkg::MODE_NEG_X: rx2_next = -W2'(px1);
      vat_pkg::MODE_SHEAR: begin
        // new x kept unclamped at full width for the y update
        rx2_next = W2'(trunc_div((W4'(px1) <<< FRAC_BITS) + W4'(pb), FRAC_BITS));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      rx2   <= rx2_next;
      ry2   <= ry2_next;
      last2 <= last1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      rx3   <= rx2;
      ry3   <= ry2;
      last3 <= last2;
      pe3   <= W3'(cfg.shear_y) * W3'(rx2);
    end
  end

  // shear y update, then clamp both coordinates
  always_comb begin
    rx_full = W4'(rx3);
    if (cfg.mode == vat_pkg::MODE_SHEAR) begin
      ry_full = trunc_div((W4'(ry3) <<< FRAC_BITS) + W4'(pe3), FRAC_BITS);
    end else begin
      ry_full = W4'(ry3);
    end
    x_hi = rx_full > COORD_MAX;
    x_lo = rx_full < COORD_MIN;
    y_hi = ry_full > COORD_MAX;
    y_lo = ry_full < COORD_MIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      x_out    <= x_hi ? CW'(COORD_MAX) : (x_lo ? CW'(COORD_MIN) : rx_full[CW-1:0]);
      y_out    <= y_hi ? CW'(COORD_MAX) : (y_lo ? CW'(COORD_MIN) : ry_full[CW-1:0]);
      last_out <= last3;
      clipped  <= x_hi || x_lo || y_hi || y_lo;
    end
  end

  a_clip_at_limit : assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      (x_out == CW'(COORD_MAX)) || (x_out == CW'(COORD_MIN)) ||
      (y_out == CW'(COORD_MAX)) || (y_out == CW'(COORD_MIN)))
    else $error("clipped word without a saturated coordinate");

  a_stage2_holds : assert property (@(posedge clk) disable iff (rst)
    v2 && !en2 |=> v2 && $stable(rx2) && $stable(ry2))
    else $error("stalled stage lost its word");

  a_no_accept_while_trig_busy : assert property (@(posedge clk) disable iff (rst)
    trig.busy |-> !in_ready)
    else $error("vertex accepted while trig unit busy");

endmodule

`default_nettype wire

@@ design/vertex_affine_transform.sv @@
// top level of the vertex affine transform
`timescale 1ns / 1ps
`default_nettype none

// Applies one 2d affine operation to a stream of polygon vertices, one vertex
// word per clock. The mode register picks translate, rotate, scale, negate y,
// negate x or shear; mode codes six and seven pass the vertex through. A new
// vertex can be taken every cycle as long as the output side keeps up and
// the trig unit is not busy; behind a stalled output the four stages keep
// filling, and in_ready only falls once every stage holds a word. Rotation
// uses cos/sin from a single iterative cordic that does one micro-rotation
// per cycle: after reset and after every write of rotation_angle, in_ready
// stays low while it recomputes. Products truncate toward zero, both
// coordinates saturate to COORD_WIDTH bits and clipped flags any saturation;
// last_in rides along to last_out. Registers are written through
// cfg_we/cfg_index/cfg_data and should only be changed with no vertex in
// flight.
module vertex_affine_transform #(
  parameter int COORD_WIDTH  = vat_pkg::COORD_WIDTH,
  parameter int FRAC_BITS    = vat_pkg::FRAC_BITS,
  parameter int CORDIC_STEPS = vat_pkg::CORDIC_STEPS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [vat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [vat_pkg::CFG_DATA_W-1:0]      cfg_data,
  // vertex input
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]       x_in,
  input  wire logic signed [COORD_WIDTH-1:0]       y_in,
  input  wire logic                                last_in,
  // transformed vertex output
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]            x_out,
  output logic signed [COORD_WIDTH-1:0]            y_out,
  output logic                                     last_out,
  output logic                                     clipped
);

  vat_pkg::cfg_t  cfg;
  vat_pkg::trig_t trig;
  logic           angle_wr;

  // register file, an angle write kicks off a new cos/sin evaluation
  vat_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .angle_wr  (angle_wr)
  );

  // cos/sin of rotation_angle in q1.14, busy while iterating
  vat_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (angle_wr),
    .angle (cfg.rotation_angle),
    .trig  (trig)
  );

  // vertex pipeline: products, combine, shear second product, clamp
  vat_pipe #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .trig      (trig),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x_in      (x_in),
    .y_in      (y_in),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_out     (x_out),
    .y_out     (y_out),
    .last_out  (last_out),
    .clipped   (clipped)
  );

endmodule

`default_nettype wire
